### sv/alac_pkg.sv
// shared types and constants of the affine-gap local alignment cell
// no dependencies; compiled first
package alac_pkg;

  localparam int unsigned MAX_COLUMNS_DEFAULT = 1024;
  localparam int unsigned SCORE_BITS_DEFAULT  = 24;

  localparam int unsigned SYM_W     = 8;
  localparam int unsigned COL_W     = 10;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned GAP_W     = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned H_OUT_W   = 23;
  localparam int unsigned F_OUT_W   = 24;
  localparam int unsigned COMPASS_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MATCH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_OPEN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_EXTEND = 2'd3;

  localparam logic signed [CFG_W-1:0] MATCH_RESET      = 16'sd80;
  localparam logic signed [CFG_W-1:0] MISMATCH_RESET   = -16'sd64;
  localparam logic [GAP_W-1:0]        GAP_OPEN_RESET   = 15'd160;
  localparam logic [GAP_W-1:0]        GAP_EXTEND_RESET = 15'd8;

  typedef struct packed {
    logic [SYM_W-1:0] query_symbol;
    logic [SYM_W-1:0] reference_symbol;
    logic [COL_W-1:0] column;
    logic             first_row;
    logic             padded_cell;
  } in_item_t;

  typedef struct packed {
    logic [H_OUT_W-1:0]        cell_score;
    logic signed [F_OUT_W-1:0] vertical_gap;
    logic [COMPASS_W-1:0]      compass;
    logic [H_OUT_W-1:0]        best_score;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     value;
  } cfg_item_t;

endpackage

### sv/alac_stream_if.sv
// valid/ready channel carrying one payload of a generic type
// no dependencies; payload types come from alac_pkg at instantiation
interface alac_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/affine_local_align_cell_top.sv
// affine-gap local alignment cell, one lane, row store in on-chip memory
// depends on alac_pkg and alac_stream_if
//
// Usage:
//   cfg_i  carries register writes (index, value); always ready. Write only
//          while no cell is in flight.
//   in_i   carries one matrix cell per transaction, row-major order.
//   out_o  returns one result per cell, in order: H, F, compass, best.
// Pipeline: a cell accepted on in_i passes the input stage (with the
//   column-modulo multiply), the row-store read and the compute into the
//   output register before it is shown on out_o.
// Throughput: one cell per cycle while out_o takes results. The row store
//   has one read and one write port; a read of the slot written in the
//   same cycle is forwarded. Left, diagonal, horizontal-gap and best
//   registers close the per-cell recurrence within the compute cycle.
// Reset: configuration returns to its defaults, the pipeline empties and
//   the running registers clear. The row store is not cleared; the first
//   row of a matrix writes it before any later row reads it.
// Stall: while out_o holds a result that is not taken, the whole pipeline
//   holds and in_i.ready stays low; otherwise in_i.ready stays high.
module affine_local_align_cell_top
  import alac_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEFAULT,
  parameter int unsigned SCORE_BITS  = SCORE_BITS_DEFAULT
) (
  input logic           clk_i,
  input logic           rst_ni,
  alac_stream_if.sink   cfg_i,
  alac_stream_if.sink   in_i,
  alac_stream_if.source out_o
);

  localparam int unsigned AW       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned SB       = SCORE_BITS;
  localparam int unsigned WW       = ((SB > CFG_W) ? SB : CFG_W) + 2;
  localparam int unsigned OW       = (SB > F_OUT_W) ? SB : F_OUT_W;
  localparam int unsigned RECIP_SH = 20;
  localparam int unsigned RECIP_W  = RECIP_SH + 1;
  localparam int unsigned NW       = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned QW       = COL_W + RECIP_W;
  localparam int unsigned PW       = COL_W + NW;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SH) / MAX_COLUMNS);
  localparam logic [NW-1:0]      NCOL  = NW'(MAX_COLUMNS);

  typedef logic signed [SB-1:0] score_t;
  typedef logic signed [WW-1:0] wide_t;
  typedef struct packed {
    score_t h;
    score_t f;
  } row_entry_t;

  localparam wide_t SAT_HI = wide_t'({1'b0, {(SB-1){1'b1}}});
  localparam wide_t SAT_LO = ~SAT_HI;

  function automatic score_t sat(wide_t v);
    score_t r;
    if (v > SAT_HI) begin
      r = score_t'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = score_t'(SAT_LO);
    end else begin
      r = score_t'(v);
    end
    return r;
  endfunction

  function automatic score_t max2(score_t a, score_t b);
    return (a > b) ? a : b;
  endfunction

  // configuration
  logic signed [CFG_W-1:0] match_q, mismatch_q;
  logic [GAP_W-1:0]        open_q, extend_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q    <= MATCH_RESET;
      mismatch_q <= MISMATCH_RESET;
      open_q     <= GAP_OPEN_RESET;
      extend_q   <= GAP_EXTEND_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        REG_MATCH:      match_q    <= signed'(cfg_i.data.value);
        REG_MISMATCH:   mismatch_q <= signed'(cfg_i.data.value);
        REG_GAP_OPEN:   open_q     <= cfg_i.data.value[GAP_W-1:0];
        REG_GAP_EXTEND: extend_q   <= cfg_i.data.value[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic adv;
  logic a_valid_q, c_valid_q, out_valid_q;
  logic rd_en, wr_en;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;
  assign rd_en      = adv && a_valid_q;
  assign wr_en      = adv && c_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q   <= in_i.valid;
      c_valid_q   <= a_valid_q;
      out_valid_q <= c_valid_q;
    end
  end

  // input stage: quotient estimate of column / MAX_COLUMNS
  logic [QW-1:0]    qprod;
  logic [COL_W-1:0] a_col_q, a_qest_q;
  logic             a_col_zero_q, a_first_q, a_equal_q;

  assign qprod = QW'(in_i.data.column) * QW'(RECIP);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_col_q      <= in_i.data.column;
      a_qest_q     <= qprod[RECIP_SH +: COL_W];
      a_col_zero_q <= (in_i.data.column == '0);
      a_first_q    <= in_i.data.first_row;
      a_equal_q    <= !in_i.data.padded_cell &&
                      (in_i.data.query_symbol == in_i.data.reference_symbol);
    end
  end

  // slot = column mod MAX_COLUMNS; estimate is exact or one short
  logic [PW-1:0]    nprod;
  logic [COL_W-1:0] rem, rem_fix;
  logic [AW-1:0]    slot;

  assign nprod   = PW'(a_qest_q) * PW'(NCOL);
  assign rem     = a_col_q - nprod[COL_W-1:0];
  assign rem_fix = (PW'(rem) >= PW'(NCOL)) ? (rem - COL_W'(NCOL)) : rem;
  assign slot    = AW'(rem_fix);

  // row store
  row_entry_t row_mem [MAX_COLUMNS];
  row_entry_t rd_q, fwd_data_q, wr_data, rd_entry;
  logic [AW-1:0] c_slot_q;
  logic          fwd_q, c_col_zero_q, c_first_q, c_equal_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      row_mem[c_slot_q] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= row_mem[slot];
    end
  end

  // same slot written while read: take the new entry
  always_ff @(posedge clk_i) begin
    if (adv) begin
      fwd_q        <= wr_en && (c_slot_q == slot);
      fwd_data_q   <= wr_data;
      c_slot_q     <= slot;
      c_col_zero_q <= a_col_zero_q;
      c_first_q    <= a_first_q;
      c_equal_q    <= a_equal_q;
    end
  end

  assign rd_entry = fwd_q ? fwd_data_q : rd_q;

  // running registers
  score_t hg_q, left_q, diag_q, best_q;

  // cell compute
  score_t hg_eff, left_eff, diag_eff, up, fprev;
  score_t e, diag, f, h, max_de, max_fz, best_d;
  wide_t  ext_w, open_w, subst_w;
  logic [COMPASS_W-1:0] compass;
  logic signed [OW-1:0] h_ext, f_ext, best_ext;

  always_comb begin
    ext_w    = wide_t'(signed'({1'b0, extend_q}));
    open_w   = wide_t'(signed'({1'b0, open_q}));
    subst_w  = c_equal_q ? wide_t'(match_q) : wide_t'(mismatch_q);
    hg_eff   = c_col_zero_q ? '0 : hg_q;
    left_eff = c_col_zero_q ? '0 : left_q;
    diag_eff = c_col_zero_q ? '0 : diag_q;
    up       = c_first_q ? '0 : rd_entry.h;
    fprev    = c_first_q ? '0 : rd_entry.f;

    e      = max2(sat(wide_t'(hg_eff) - ext_w), sat(wide_t'(left_eff) - open_w));
    diag   = sat(wide_t'(diag_eff) + subst_w);
    f      = max2(sat(wide_t'(fprev) - ext_w), sat(wide_t'(up) - open_w));
    max_de = max2(diag, e);
    max_fz = max2(f, '0);
    h      = max2(max_de, max_fz);
    compass = {diag >= e, f >= 0, max_de >= max_fz};
    best_d = (c_first_q && c_col_zero_q) ? h : max2(best_q, h);

    wr_data.h = h;
    wr_data.f = f;

    h_ext    = OW'(h);
    f_ext    = OW'(f);
    best_ext = OW'(best_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hg_q   <= '0;
      left_q <= '0;
      diag_q <= '0;
      best_q <= '0;
    end else if (wr_en) begin
      hg_q   <= e;
      left_q <= h;
      diag_q <= up;
      best_q <= best_d;
    end
  end

  // output register
  out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      out_q.cell_score   <= h_ext[H_OUT_W-1:0];
      out_q.vertical_gap <= f_ext[F_OUT_W-1:0];
      out_q.compass      <= compass;
      out_q.best_score   <= best_ext[H_OUT_W-1:0];
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

### sv/alac_checker.sv
// port-level checks of the alignment cell over time, bound to the top level
// depends on alac_pkg and affine_local_align_cell_top
module alac_checker
  import alac_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  logic [2:0] inflight_q;
  logic       in_txn, out_txn;

  assign in_txn  = in_valid_i && in_ready_i;
  assign out_txn = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 3'(in_txn) - 3'(out_txn);
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // input is held back only by a stalled result
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input refused without output stall");

  // three pipeline slots at most
  a_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd3)
    else $error("more cells in flight than pipeline slots");

  // neither diagonal nor left wins and a negative vertical gap: score zero
  a_compass_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.compass[0] && !out_data_i.compass[1]
      |-> out_data_i.cell_score == '0)
    else $error("compass says zero score");

  // vertical gap wins: score equals it
  a_compass_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.compass[0] && out_data_i.compass[1]
      |-> out_data_i.cell_score == out_data_i.vertical_gap[H_OUT_W-1:0])
    else $error("compass says vertical gap score");

endmodule

bind affine_local_align_cell_top alac_checker u_alac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
